// ===== rtl/cws_pkg.sv =====
// ----------------------------------------------------------------------------
// cws_pkg: shared types, constants and tables of the waveform shaper
// Holds the mode codes, register indexes, the quarter-wave sine table, the
// stepped-triangle table and the rounding helper used by shaper and filter.
// ----------------------------------------------------------------------------
package cws_pkg;

	localparam int PHASE_BITS       = 16;
	localparam int WAVE_LENGTH      = 32;
	localparam int SINE_TABLE_DEPTH = 256;

	localparam int PHASE_W     = 16;
	localparam int AMP_W       = 16;
	localparam int SEL_W       = 4;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int VAL_W       = 18;
	localparam int FILT_W      = 24;
	localparam int WT_IDX_W    = 5;
	localparam int NIB_W       = 4;
	localparam int SIN_IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int RND_W       = 48;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SELECT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_LOW  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_HIGH = 2'd2;

	// shape codes of wave_select
	localparam logic [SEL_W-1:0] WAVE_SINE    = 4'd0;
	localparam logic [SEL_W-1:0] WAVE_RSINE   = 4'd1;
	localparam logic [SEL_W-1:0] WAVE_SAW     = 4'd2;
	localparam logic [SEL_W-1:0] WAVE_RSAW    = 4'd3;
	localparam logic [SEL_W-1:0] WAVE_SQ50    = 4'd4;
	localparam logic [SEL_W-1:0] WAVE_SQ25    = 4'd5;
	localparam logic [SEL_W-1:0] WAVE_SQ12    = 4'd6;
	localparam logic [SEL_W-1:0] WAVE_TRI     = 4'd7;
	localparam logic [SEL_W-1:0] WAVE_STEP    = 4'd8;
	localparam logic [SEL_W-1:0] WAVE_TABLE   = 4'd9;
	localparam logic [SEL_W-1:0] WAVE_FSQ50   = 4'd10;
	localparam logic [SEL_W-1:0] WAVE_FSQ25   = 4'd11;
	localparam logic [SEL_W-1:0] WAVE_FSQ12   = 4'd12;
	localparam logic [SEL_W-1:0] WAVE_LAST    = WAVE_FSQ12;
	localparam logic [SEL_W-1:0] WAVE_RESET   = WAVE_SQ50;

	localparam logic signed [VAL_W-1:0] AMP_ONE  = 18'sd16384;
	localparam logic signed [VAL_W-1:0] AMP_TWO  = 18'sd32768;
	localparam logic signed [VAL_W-1:0] AMP_FOUR = 18'sd65536;

	typedef logic [14:0] sine_entry_t;
	typedef sine_entry_t sine_rom_t [0:SINE_TABLE_DEPTH];
	typedef logic [15:0] step_tab_t [0:15];

	typedef struct packed {
		logic                    filt_sel;
		logic                    filt_high;
		logic signed [VAL_W-1:0] value;
	} shape_t;

	// quarter-wave sine, Q30 Taylor series evaluated at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t         rom;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint unsigned   v;
		longint            sum;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x    = HALF_PI_Q30 * 64'(i) / SINE_TABLE_DEPTH;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int k = 1; k <= 8; k++) begin
				term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = (64'(sum) * 64'd16384 + (64'd1 << 29)) >> 30;
			if (v > 64'd16384) begin
				v = 64'd16384;
			end
			rom[i] = 15'(v);
		end
		return rom;
	endfunction

	// rise of the stepped triangle: (2k * 16384 + 7) / 15
	function automatic step_tab_t build_step_tab();
		step_tab_t tab;
		for (int k = 0; k < 16; k++) begin
			tab[k] = 16'((2 * k * 16384 + 7) / 15);
		end
		return tab;
	endfunction

	localparam sine_rom_t SINE_ROM  = build_sine_rom();
	localparam step_tab_t STEP_RISE = build_step_tab();

	// divide by 2^s, rounding half away from zero
	function automatic logic signed [RND_W-1:0] round_shift(
		input logic signed [RND_W-1:0] v,
		input int                      s
	);
		logic [RND_W-1:0] m;
		m = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
		m = (m + (RND_W'(1) << (s - 1))) >> s;
		return v[RND_W-1] ? -$signed(m) : $signed(m);
	endfunction

endpackage

// ===== rtl/cws_channels.sv =====
// ----------------------------------------------------------------------------
// cws_channels: handshake channels of the waveform shaper
// Phase channel into the block and amplitude channel out of it.
// ----------------------------------------------------------------------------
interface cws_phase_if import cws_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PHASE_W-1:0] phase;

	modport source (output valid, output phase, input ready);
	modport sink (input valid, input phase, output ready);
endinterface

interface cws_amp_if import cws_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [AMP_W-1:0] amplitude;

	modport source (output valid, output amplitude, input ready);
	modport sink (input valid, input amplitude, output ready);
endinterface

// ===== rtl/cws_shaper.sv =====
// ----------------------------------------------------------------------------
// cws_shaper: stateless shape generation
// Turns one phase word into the unfiltered shape value and tells the
// high-pass stage which square level to take in the filtered modes.
// ----------------------------------------------------------------------------
module cws_shaper import cws_pkg::*; (
	input  logic [SEL_W-1:0]      wave_select,
	input  logic [PHASE_BITS-1:0] phase,
	input  logic [CFG_DATA_W-1:0] samples_low,
	input  logic [CFG_DATA_W-1:0] samples_high,
	output shape_t                shape
);

	localparam logic [PHASE_BITS-1:0] PH_HALF    = {1'b1, {(PHASE_BITS - 1){1'b0}}};
	localparam logic [PHASE_BITS-1:0] PH_QUARTER = PH_HALF >> 1;
	localparam logic [PHASE_BITS-1:0] PH_EIGHTH  = PH_HALF >> 2;
	localparam logic [PHASE_BITS-1:0] PH_3Q      = PH_HALF | PH_QUARTER;
	localparam int SIN_PROD_W = PHASE_BITS - 2 + SIN_IDX_W;
	localparam int WT_PROD_W  = PHASE_BITS + 6;

	logic [1:0]                quad;
	logic [PHASE_BITS-3:0]     offset;
	logic [SIN_PROD_W-1:0]     sin_prod;
	logic [SIN_IDX_W-1:0]      sin_idx;
	logic [SIN_IDX_W-1:0]      sin_addr;
	logic signed [VAL_W-1:0]   sine_mag;
	logic signed [VAL_W-1:0]   sine;
	logic [PHASE_BITS+13:0]    scaled;
	logic [14:0]               saw_t;
	logic [15:0]               tri_t;
	logic signed [VAL_W-1:0]   saw;
	logic signed [VAL_W-1:0]   tri_v;
	logic [3:0]                step_k;
	logic signed [VAL_W-1:0]   step_rise;
	logic signed [VAL_W-1:0]   step_v;
	logic [WT_PROD_W-1:0]      wt_prod;
	logic [WT_IDX_W-1:0]       wt_idx;
	logic [2*CFG_DATA_W-1:0]   wt_all;
	logic [NIB_W-1:0]          nib;
	logic signed [VAL_W-1:0]   table_v;
	logic signed [RND_W-1:0]   rsine;
	logic signed [RND_W-1:0]   rsaw;
	logic                      sq50;
	logic                      sq25;
	logic                      sq12;

	// sine: quadrant from the top bits, mirrored address on odd quadrants
	assign quad     = phase[PHASE_BITS-1 -: 2];
	assign offset   = phase[PHASE_BITS-3:0];
	assign sin_prod = SIN_PROD_W'(offset) * SIN_PROD_W'(SINE_TABLE_DEPTH);
	assign sin_idx  = sin_prod[SIN_PROD_W-1 -: SIN_IDX_W];
	assign sin_addr = quad[0] ? SIN_IDX_W'(SINE_TABLE_DEPTH) - sin_idx : sin_idx;
	assign sine_mag = VAL_W'(SINE_ROM[sin_addr]);
	assign sine     = quad[1] ? -sine_mag : sine_mag;
	assign rsine    = round_shift(RND_W'(sine), 12);

	// saw and triangle: phase scaled by 2^14 over half / quarter cycle
	assign scaled = {phase, 14'b0};
	assign saw_t  = 15'(scaled >> (PHASE_BITS - 1));
	assign tri_t  = 16'(scaled >> (PHASE_BITS - 2));
	assign saw    = (phase > PH_HALF) ? $signed(VAL_W'(saw_t)) - AMP_TWO
	                                  : $signed(VAL_W'(saw_t));
	assign rsaw   = round_shift(RND_W'(saw), 13);

	always_comb begin
		if (phase > PH_3Q) begin
			tri_v = $signed(VAL_W'(tri_t)) - AMP_FOUR;
		end else if (phase > PH_QUARTER) begin
			tri_v = AMP_TWO - $signed(VAL_W'(tri_t));
		end else begin
			tri_v = $signed(VAL_W'(tri_t));
		end
	end

	// stepped triangle: 16 levels up in the first half, down in the second
	assign step_k    = phase[PHASE_BITS-2 -: 4];
	assign step_rise = $signed(VAL_W'(STEP_RISE[step_k]));
	assign step_v    = phase[PHASE_BITS-1] ? AMP_ONE - step_rise : step_rise - AMP_ONE;

	// wavetable: one nibble of the two sample registers
	assign wt_prod = WT_PROD_W'(phase) * WT_PROD_W'(WAVE_LENGTH);
	assign wt_idx  = wt_prod[PHASE_BITS +: WT_IDX_W];
	assign wt_all  = {samples_high, samples_low};
	assign nib     = wt_all[{wt_idx, 2'b00} +: NIB_W];
	assign table_v = $signed(VAL_W'({nib, 11'b0})) - AMP_ONE;

	assign sq50 = (phase <= PH_HALF);
	assign sq25 = (phase <= PH_QUARTER);
	assign sq12 = (phase <= PH_EIGHTH);

	always_comb begin
		shape = '0;
		case (wave_select)
			WAVE_SINE:  shape.value = sine;
			WAVE_RSINE: shape.value = VAL_W'(rsine <<< 12);
			WAVE_SAW:   shape.value = saw;
			WAVE_RSAW:  shape.value = VAL_W'(rsaw <<< 13);
			WAVE_SQ50:  shape.value = sq50 ? AMP_ONE : -AMP_ONE;
			WAVE_SQ25:  shape.value = sq25 ? AMP_ONE : -AMP_ONE;
			WAVE_SQ12:  shape.value = sq12 ? AMP_ONE : -AMP_ONE;
			WAVE_TRI:   shape.value = tri_v;
			WAVE_STEP:  shape.value = step_v;
			WAVE_TABLE: shape.value = table_v;
			WAVE_FSQ50: begin
				shape.filt_sel  = 1'b1;
				shape.filt_high = sq50;
			end
			WAVE_FSQ25: begin
				shape.filt_sel  = 1'b1;
				shape.filt_high = sq25;
			end
			WAVE_FSQ12: begin
				shape.filt_sel  = 1'b1;
				shape.filt_high = sq12;
			end
			default:    shape = '0;
		endcase
	end

endmodule

// ===== rtl/cws_filter.sv =====
// ----------------------------------------------------------------------------
// cws_filter: one-pole high-pass for the filtered square modes
// Keeps the 24-bit Q1.22 filter memory; the memory advances only on an
// item that uses the filter.
// ----------------------------------------------------------------------------
module cws_filter import cws_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    high,
	output logic signed [VAL_W-1:0] value
);

	localparam logic signed [RND_W-1:0] X_ONE    = RND_W'(1) <<< 22;
	localparam logic signed [RND_W-1:0] COEF     = RND_W'(65274);
	localparam logic signed [RND_W-1:0] MEM_MAX  = RND_W'(8388607);
	localparam logic signed [RND_W-1:0] MEM_MIN  = -RND_W'(8388608);

	logic signed [FILT_W-1:0] mem_q;
	logic signed [RND_W-1:0]  x;
	logic signed [RND_W-1:0]  y;
	logic signed [RND_W-1:0]  prod;
	logic signed [RND_W-1:0]  next_raw;
	logic signed [FILT_W-1:0] next_mem;

	assign x        = high ? X_ONE : -X_ONE;
	assign y        = x - RND_W'(mem_q);
	assign prod     = y * COEF;
	assign next_raw = x - round_shift(prod, 16);
	assign value    = VAL_W'(round_shift(y, 8));

	always_comb begin
		if (next_raw > MEM_MAX) begin
			next_mem = FILT_W'(MEM_MAX);
		end else if (next_raw < MEM_MIN) begin
			next_mem = FILT_W'(MEM_MIN);
		end else begin
			next_mem = FILT_W'(next_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q <= '0;
		end else if (en) begin
			mem_q <= next_mem;
		end
	end

`ifndef NO_ASSERTIONS
	a_mem_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(mem_q))
		else $error("filter memory moved without a filtered item");
`endif

endmodule

// ===== rtl/chiptune_waveform_shaper.sv =====
// ----------------------------------------------------------------------------
// chiptune_waveform_shaper: oscillator waveform shaper, top level
// Takes one phase word per item and returns one saturated Q2.14 amplitude.
// ----------------------------------------------------------------------------
// The block accepts one phase item every clock cycle while the output is
// not stalled: an input register holds the phase, one pass of shaping
// logic (sine table, saw, squares, triangles, wavetable, or the high-pass
// filter for the filtered squares) computes the sample, and an output
// register holds it until taken. The filter memory updates in the same
// edge that loads the output register, so consecutive filtered items
// follow each other without a gap. A stalled output register holds the
// input side only when the input register is full as well. Configuration
// (wave_select, the two wavetable words) is written through cfg_we /
// cfg_index / cfg_data; the user must write it only while no item is in
// flight, which the block does not enforce; index 3 is ignored. After
// reset the shape is the 50 percent square and the filter memory is zero.
// ----------------------------------------------------------------------------
module chiptune_waveform_shaper import cws_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	cws_phase_if.sink              phase_ch,
	cws_amp_if.source              sample_ch
);

	localparam logic signed [VAL_W-1:0] SAT_MAX = 18'sd32767;
	localparam logic signed [VAL_W-1:0] SAT_MIN = -18'sd32768;

	// configuration registers
	logic [SEL_W-1:0]      wave_select_q;
	logic [CFG_DATA_W-1:0] samples_low_q;
	logic [CFG_DATA_W-1:0] samples_high_q;

	// input stage and output stage
	logic                    valid_s1;
	logic [PHASE_BITS-1:0]   phase_s1;
	logic                    valid_s2;
	logic signed [AMP_W-1:0] amp_s2;

	logic                    take_in;
	logic                    advance;
	shape_t                  shape;
	logic signed [VAL_W-1:0] filt_value;
	logic signed [VAL_W-1:0] pre_sat;
	logic signed [AMP_W-1:0] sat_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_select_q  <= WAVE_RESET;
			samples_low_q  <= '0;
			samples_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WAVE_SELECT:  wave_select_q  <= cfg_data[SEL_W-1:0];
				CFG_SAMPLES_LOW:  samples_low_q  <= cfg_data;
				CFG_SAMPLES_HIGH: samples_high_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// advance the output register when it is empty or being taken;
	// take a new item whenever the input register can move on
	assign advance        = !valid_s2 || sample_ch.ready;
	assign phase_ch.ready = !valid_s1 || advance;
	assign take_in        = phase_ch.valid && phase_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (phase_ch.ready) begin
			valid_s1 <= phase_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			phase_s1 <= phase_ch.phase[PHASE_BITS-1:0];
		end
	end

	cws_shaper u_shaper (
		.wave_select  (wave_select_q),
		.phase        (phase_s1),
		.samples_low  (samples_low_q),
		.samples_high (samples_high_q),
		.shape        (shape)
	);

	// step the filter only for a filtered item that moves to the output
	cws_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance && valid_s1 && shape.filt_sel),
		.high   (shape.filt_high),
		.value  (filt_value)
	);

	// pick the source and clamp to 16 bits (full-scale filter output clips)
	assign pre_sat = shape.filt_sel ? filt_value : shape.value;

	always_comb begin
		if (pre_sat > SAT_MAX) begin
			sat_value = AMP_W'(SAT_MAX);
		end else if (pre_sat < SAT_MIN) begin
			sat_value = AMP_W'(SAT_MIN);
		end else begin
			sat_value = AMP_W'(pre_sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			amp_s2 <= sat_value;
		end
	end

	assign sample_ch.valid     = valid_s2;
	assign sample_ch.amplitude = amp_s2;

`ifndef NO_ASSERTIONS
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> valid_s1)
		else $error("accepted item missing from input register");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1) |=> valid_s2)
		else $error("item lost between input and output register");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && (wave_select_q > WAVE_LAST)) |=> (amp_s2 == '0))
		else $error("unused shape code gave a nonzero sample");

	a_square_level: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && (wave_select_q == WAVE_SQ50))
		|=> ((amp_s2 == AMP_W'(AMP_ONE)) || (amp_s2 == -AMP_W'(AMP_ONE))))
		else $error("square sample is not full scale");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the chiptune waveform shaper
// Streams phase items into the shaper and compares every amplitude with a
// local model of all thirteen shapes and the high-pass filter. Shape and
// wavetable registers change between bursts while the block is empty. Both
// channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top import cws_pkg::*; ();

	// register index that the block must ignore
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	// phase landmarks and amplitude scale
	localparam longint AMP_UNIT  = 64'sd16384;
	localparam longint HALF_P    = 64'sd32768;
	localparam longint QUARTER_P = 64'sd16384;
	localparam longint EIGHTH_P  = 64'sd8192;

	// high-pass filter in Q1.22, coefficient 0.996 in Q16
	localparam longint HP_ONE  = 64'sd4194304;
	localparam longint HP_COEF = 64'sd65274;
	localparam longint HP_MAX  = 64'sd8388607;
	localparam longint HP_MIN  = -64'sd8388608;

	localparam int RANDOM_ITEMS = 300;
	localparam int SETTLE_ITEMS = 150;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_WRITE,
		OP_DRAIN
	} op_kind_t;

	// one entry of the stimulus list: a phase item, a register write, or a
	// pause until the block is empty
	typedef struct packed {
		op_kind_t               kind;
		logic [PHASE_W-1:0]     phase;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
		logic [7:0]             idle_pct;
	} stim_op_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	cws_phase_if phase_ch ();
	cws_amp_if   sample_ch ();

	chiptune_waveform_shaper DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.phase_ch  (phase_ch),
		.sample_ch (sample_ch)
	);

	// model state: registers, filter memory and the sine quarter table
	logic [SEL_W-1:0]      sel_q  = WAVE_RESET;
	logic [CFG_DATA_W-1:0] tab_lo = '0;
	logic [CFG_DATA_W-1:0] tab_hi = '0;
	longint                hp_mem = 0;
	longint                sine_q [0:SINE_TABLE_DEPTH];

	stim_op_t                ops [$];
	logic signed [AMP_W-1:0] amp_expected [$];

	int         issued;
	int         received;
	int         errors = 0;
	int         gap_cnt;
	int         stall_cnt;
	logic [7:0] idle_pct_q;

	// driver scratch
	stim_op_t               head;
	logic                   took;
	logic                   nxt_valid;
	logic [PHASE_W-1:0]     nxt_phase;
	logic                   nxt_we;
	logic [CFG_INDEX_W-1:0] nxt_index;
	logic [CFG_DATA_W-1:0]  nxt_data;

	// monitor scratch
	logic                    nxt_ready;
	logic signed [AMP_W-1:0] want;

	// ------------------------------------------------------------------------
	// Model of the shaper
	// ------------------------------------------------------------------------

	// divide by 2^s, halves away from zero
	function automatic longint rnd_half_away(input longint v, input int s);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (s - 1))) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	// one entry of the quarter sine: Taylor series in Q30, scaled to Q14
	function automatic longint sine_entry(input int i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint          acc;
		x    = HALF_PI_Q30 * 64'(i) / 64'(SINE_TABLE_DEPTH);
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		v = (64'(acc) * 64'd16384 + (64'd1 << 29)) >> 30;
		if (v > 64'd16384) begin
			v = 64'd16384;
		end
		return longint'(v);
	endfunction

	// full sine from the quarter table: mirror in odd quadrants, negate in
	// the second half
	function automatic longint sine_at(input logic [PHASE_W-1:0] ph);
		logic [1:0] quad;
		int         idx;
		longint     v;
		quad = ph[15:14];
		idx  = int'(ph[13:6]);
		v    = quad[0] ? sine_q[SINE_TABLE_DEPTH - idx] : sine_q[idx];
		return quad[1] ? -v : v;
	endfunction

	// one-pole high-pass on a +-1.0 square; updates the filter memory
	function automatic longint hp_step(input bit high);
		longint x;
		longint y;
		longint c;
		x = high ? HP_ONE : -HP_ONE;
		y = x - hp_mem;
		c = x - rnd_half_away(y * HP_COEF, 16);
		if (c > HP_MAX) begin
			c = HP_MAX;
		end
		if (c < HP_MIN) begin
			c = HP_MIN;
		end
		hp_mem = c;
		return rnd_half_away(y, 8);
	endfunction

	// amplitude of one phase item under the current registers
	function automatic logic signed [AMP_W-1:0] shape_sample(input logic [PHASE_W-1:0] ph);
		longint     p;
		longint     r;
		longint     k;
		logic [3:0] nib;
		int         widx;
		p = longint'({48'd0, ph});
		r = 0;
		case (sel_q)
			WAVE_SINE: r = sine_at(ph);
			WAVE_RSINE: r = rnd_half_away(sine_at(ph), 12) * 4096;
			WAVE_SAW, WAVE_RSAW: begin
				r = p * AMP_UNIT / HALF_P;
				if (p > HALF_P) begin
					r = r - 2 * AMP_UNIT;
				end
				if (sel_q == WAVE_RSAW) begin
					r = rnd_half_away(r, 13) * 8192;
				end
			end
			WAVE_SQ50: r = (p <= HALF_P) ? AMP_UNIT : -AMP_UNIT;
			WAVE_SQ25: r = (p <= QUARTER_P) ? AMP_UNIT : -AMP_UNIT;
			WAVE_SQ12: r = (p <= EIGHTH_P) ? AMP_UNIT : -AMP_UNIT;
			WAVE_TRI: begin
				r = p * AMP_UNIT / QUARTER_P;
				if (p > 3 * QUARTER_P) begin
					r = r - 4 * AMP_UNIT;
				end else if (p > QUARTER_P) begin
					r = 2 * AMP_UNIT - r;
				end
			end
			WAVE_STEP: begin
				if (p < HALF_P) begin
					k = p * 16 / HALF_P;
					r = -AMP_UNIT + (2 * k * AMP_UNIT + 7) / 15;
				end else begin
					k = (p - HALF_P) * 16 / HALF_P;
					r = AMP_UNIT - (2 * k * AMP_UNIT + 7) / 15;
				end
			end
			WAVE_TABLE: begin
				widx = int'(ph[15:11]);
				nib  = (widx < 16) ? tab_lo[4 * widx +: 4] : tab_hi[4 * (widx - 16) +: 4];
				r    = longint'({60'd0, nib}) * 2048 - AMP_UNIT;
			end
			WAVE_FSQ50: r = hp_step(p <= HALF_P);
			WAVE_FSQ25: r = hp_step(p <= QUARTER_P);
			WAVE_FSQ12: r = hp_step(p <= EIGHTH_P);
			default: r = 0;
		endcase
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		return AMP_W'(r);
	endfunction

	function automatic void apply_write(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_WAVE_SELECT: sel_q = d[SEL_W-1:0];
			CFG_SAMPLES_LOW: tab_lo = d;
			CFG_SAMPLES_HIGH: tab_hi = d;
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus list builders
	// ------------------------------------------------------------------------

	function automatic void push_sample(input logic [PHASE_W-1:0] ph, input int pct);
		stim_op_t o;
		o.kind     = OP_SAMPLE;
		o.phase    = ph;
		o.index    = CFG_WAVE_SELECT;
		o.data     = '0;
		o.idle_pct = 8'(pct);
		ops.push_back(o);
	endfunction

	function automatic void push_write(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] d);
		stim_op_t o;
		o.kind     = OP_WRITE;
		o.phase    = '0;
		o.index    = idx;
		o.data     = d;
		o.idle_pct = '0;
		ops.push_back(o);
	endfunction

	function automatic void push_drain();
		stim_op_t o;
		o.kind     = OP_DRAIN;
		o.phase    = '0;
		o.index    = CFG_WAVE_SELECT;
		o.data     = '0;
		o.idle_pct = '0;
		ops.push_back(o);
	endfunction

	// select a shape with random junk above the 4-bit field
	function automatic void push_mode(input logic [SEL_W-1:0] m);
		logic [CFG_DATA_W-1:0] d;
		d = {$urandom, $urandom};
		d[SEL_W-1:0] = m;
		push_write(CFG_WAVE_SELECT, d);
	endfunction

	// phases on and next to the eighth, quarter, half and three-quarter boundaries and the ends of the range
	function automatic logic [PHASE_W-1:0] corner_phase();
		logic [PHASE_W-1:0] c;
		case ($urandom_range(0, 15))
			0: c = 16'd0;
			1: c = 16'd1;
			2: c = 16'd8191;
			3: c = 16'd8192;
			4: c = 16'd8193;
			5: c = 16'd16383;
			6: c = 16'd16384;
			7: c = 16'd16385;
			8: c = 16'd32767;
			9: c = 16'd32768;
			10: c = 16'd32769;
			11: c = 16'd49151;
			12: c = 16'd49152;
			13: c = 16'd49153;
			14: c = 16'd65534;
			default: c = 16'd65535;
		endcase
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Clock; drive every input to a known value from time zero
	// ------------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_WAVE_SELECT;
		cfg_data       = '0;
		phase_ch.valid = 1'b0;
		phase_ch.phase = '0;
		sample_ch.ready = 1'b0;
		clk            = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Driver: take the next entry of the list. A phase item stays on the
	// channel until accepted; a write or a pause waits until every accepted
	// item has come back, so registers only change while the block is empty.
	// The model runs at acceptance, in acceptance order.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ch.valid <= 1'b0;
			phase_ch.phase <= '0;
			cfg_we         <= 1'b0;
			cfg_index      <= CFG_WAVE_SELECT;
			cfg_data       <= '0;
			issued         <= 0;
			idle_pct_q     <= '0;
			gap_cnt = 0;
		end else begin
			took      = phase_ch.valid && phase_ch.ready;
			nxt_valid = phase_ch.valid;
			nxt_phase = phase_ch.phase;
			nxt_we    = 1'b0;
			nxt_index = cfg_index;
			nxt_data  = cfg_data;
			if (took) begin
				amp_expected.push_back(shape_sample(phase_ch.phase));
				issued   <= issued + 1;
				nxt_valid = 1'b0;
			end
			// channel free: count down an idle burst, else serve the list
			if (!nxt_valid && ops.size() != 0) begin
				if (gap_cnt > 0) begin
					gap_cnt = gap_cnt - 1;
				end else begin
					head = ops[0];
					case (head.kind)
						OP_SAMPLE: begin
							nxt_valid = 1'b0 | 1'b1;
							nxt_phase = head.phase;
							idle_pct_q <= head.idle_pct;
							void'(ops.pop_front());
							if (head.idle_pct != 0 &&
								$urandom_range(0, 99) < head.idle_pct) begin
								gap_cnt = $urandom_range(1, 15);
							end
						end
						OP_WRITE: begin
							if (!took && issued == received) begin
								nxt_we    = 1'b1;
								nxt_index = head.index;
								nxt_data  = head.data;
								apply_write(head.index, head.data);
								void'(ops.pop_front());
							end
						end
						default: begin
							if (!took && issued == received) begin
								void'(ops.pop_front());
							end
						end
					endcase
				end
			end
			phase_ch.valid <= nxt_valid;
			phase_ch.phase <= nxt_phase;
			cfg_we         <= nxt_we;
			cfg_index      <= nxt_index;
			cfg_data       <= nxt_data;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: compare each accepted amplitude with the oldest prediction and
	// stall the output side in bursts whose rate follows the current item
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.ready <= 1'b0;
			received        <= 0;
			stall_cnt = 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				if (amp_expected.size() == 0) begin
					$display("%0t: amplitude %0d arrived with nothing pending",
						$time, sample_ch.amplitude);
					errors = errors + 1;
				end else begin
					want = amp_expected.pop_front();
					if (want !== sample_ch.amplitude) begin
						$display("%0t: amplitude mismatch: expected %0d, actual %0d",
							$time, want, sample_ch.amplitude);
						errors = errors + 1;
					end
				end
				received <= received + 1;
			end
			if (stall_cnt > 0) begin
				stall_cnt = stall_cnt - 1;
				nxt_ready = 1'b0;
			end else if (idle_pct_q != 0 && $urandom_range(0, 399) < idle_pct_q) begin
				stall_cnt = $urandom_range(0, 14);
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
			sample_ch.ready <= nxt_ready;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int         count;
		int         n;
		int         pct;
		logic [3:0] m;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			sine_q[i] = sine_entry(i);
		end

		// out of reset the shape is the 50 percent square
		push_sample(16'd0, 0);
		push_sample(16'd32768, 0);
		push_sample(16'd32769, 0);
		push_sample(16'd65535, 0);
		// a write to the unused index must change nothing
		push_write(CFG_UNUSED, '1);
		push_sample(16'd16384, 0);
		// wavetable: entry i holds i below, a fixed pattern above; select
		// with all upper data bits set to check that only four bits count
		push_write(CFG_SAMPLES_LOW, 64'hFEDC_BA98_7654_3210);
		push_write(CFG_SAMPLES_HIGH, 64'h0F1E_2D3C_4B5A_6978);
		push_write(CFG_WAVE_SELECT, {60'hFFF_FFFF_FFFF_FFFF, WAVE_TABLE});
		push_sample(16'd0, 0);
		push_sample(16'd30719, 0);
		push_sample(16'd32768, 0);
		push_sample(16'd65535, 0);
		push_mode(WAVE_SINE);
		push_sample(16'd16383, 0);
		push_sample(16'd49152, 0);
		push_mode(WAVE_RSINE);
		push_sample(16'd6000, 0);
		push_mode(WAVE_SAW);
		push_sample(16'd32768, 0);
		push_sample(16'd32769, 0);
		// rough saw on an exact half step rounds away from zero
		push_mode(WAVE_RSAW);
		push_sample(16'd24576, 0);
		push_mode(WAVE_SQ25);
		push_sample(16'd16384, 0);
		push_sample(16'd16385, 0);
		push_mode(WAVE_SQ12);
		push_sample(16'd8192, 0);
		push_mode(WAVE_TRI);
		push_sample(16'd16385, 0);
		push_sample(16'd49153, 0);
		push_mode(WAVE_STEP);
		push_sample(16'd32767, 0);
		push_sample(16'd32768, 0);
		// unused selector gives silence and leaves the filter alone
		push_mode(4'd15);
		push_sample(16'd12345, 0);
		push_mode(WAVE_FSQ50);
		push_sample(16'd100, 0);
		push_sample(16'd40000, 0);

		// hold the 12.5 percent filtered square low for a while so the
		// filter memory drifts toward -1.0, then step high: the output
		// jumps well above 1.0
		push_mode(WAVE_FSQ12);
		for (int i = 0; i < SETTLE_ITEMS; i++) begin
			push_sample(16'($urandom_range(8193, 65535)), 0);
		end
		push_sample(16'd0, 0);
		push_sample(16'd65535, 0);
		push_sample(16'd0, 0);

		// random bursts, each under a fresh register setting; the first
		// pause makes the sender wait for every result
		push_drain();
		count = 0;
		while (count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				push_drain();
			end
			case ($urandom_range(0, 5))
				0: push_write(CFG_SAMPLES_LOW, {$urandom, $urandom});
				1: push_write(CFG_SAMPLES_HIGH, {$urandom, $urandom});
				2: begin
					push_write(CFG_SAMPLES_LOW, '0);
					push_write(CFG_SAMPLES_HIGH, '1);
				end
				3: begin
					push_write(CFG_SAMPLES_LOW, '1);
					push_write(CFG_SAMPLES_HIGH, '0);
				end
				4: push_write(CFG_UNUSED, {$urandom, $urandom});
				default: ;
			endcase
			if ($urandom_range(0, 9) == 0) begin
				m = 4'($urandom_range(13, 15));
			end else begin
				m = 4'($urandom_range(0, 12));
			end
			push_mode(m);
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 10;
				2: pct = 30;
				default: pct = 60;
			endcase
			// keep the tail of the run free of idling
			if (count >= RANDOM_ITEMS - 60) begin
				pct = 0;
			end
			n = $urandom_range(5, 30);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					push_sample(corner_phase(), pct);
				end else begin
					push_sample(16'($urandom), pct);
				end
			end
			count = count + n;
		end

		// release reset on a falling clock edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the list to empty and every result to come back
		while (ops.size() != 0 || phase_ch.valid || issued != received) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (amp_expected.size() != 0) begin
			$display("%0t: %0d amplitudes still pending", $time, amp_expected.size());
			errors = errors + 1;
		end
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== chiptune_waveform_shaper.f =====
rtl/cws_pkg.sv
rtl/cws_channels.sv
rtl/cws_shaper.sv
rtl/cws_filter.sv
rtl/chiptune_waveform_shaper.sv
tb/sv/tb_top.sv
